// ----- hw/rtl/mpp_pkg.sv -----
package mpp_pkg;

    localparam int MaxHeight    = 64;
    localparam int MaxWidth     = 64;
    localparam int ChannelBlock = 16;
    localparam int Lanes        = 4;

    localparam int RowW   = $clog2(MaxHeight);
    localparam int ColW   = $clog2(MaxWidth);
    localparam int RowsW  = $clog2(ChannelBlock / Lanes);
    localparam int AddrW  = RowW + ColW + RowsW;
    localparam int LaneBits = 32 * Lanes;

    localparam logic [31:0] NegFltMax = 32'hFF7F_FFFF;

    localparam logic [3:0] RegKh = 4'd0;
    localparam logic [3:0] RegKw = 4'd1;
    localparam logic [3:0] RegSh = 4'd2;
    localparam logic [3:0] RegSw = 4'd3;
    localparam logic [3:0] RegPt = 4'd4;
    localparam logic [3:0] RegPl = 4'd5;
    localparam logic [3:0] RegIh = 4'd6;
    localparam logic [3:0] RegIw = 4'd7;

    localparam logic ActLoad  = 1'b0;
    localparam logic ActQuery = 1'b1;

    typedef struct packed {
        logic [6:0] kernel_height;
        logic [6:0] kernel_width;
        logic [6:0] stride_height;
        logic [6:0] stride_width;
        logic [5:0] pad_top;
        logic [5:0] pad_left;
        logic [6:0] image_height;
        logic [6:0] image_width;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_READ,
        S_CMP,
        S_OUT
    } t_state;

    // a > b for fp32 bit patterns; false if either is NaN
    function automatic logic fp_gt(input logic [31:0] a, input logic [31:0] b);
        logic a_nan;
        logic b_nan;
        logic a_zero;
        logic b_zero;
        logic res;
        a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        if (a_nan || b_nan || (a_zero && b_zero)) begin
            res = 1'b0;
        end else if (a[31] != b[31]) begin
            res = !a[31];
        end else if (!a[31]) begin
            res = a[30:0] > b[30:0];
        end else begin
            res = a[30:0] < b[30:0];
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/mpp_if.sv -----
interface mpp_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [6:0]  row;
    logic [6:0]  col;
    logic [1:0]  slice;
    logic [31:0] in_lane0;
    logic [31:0] in_lane1;
    logic [31:0] in_lane2;
    logic [31:0] in_lane3;
    modport source (output valid, action, row, col, slice, in_lane0, in_lane1, in_lane2,
                    in_lane3, input ready);
    modport sink (input valid, action, row, col, slice, in_lane0, in_lane1, in_lane2,
                  in_lane3, output ready);
endinterface

interface mpp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] max_lane0;
    logic [31:0] max_lane1;
    logic [31:0] max_lane2;
    logic [31:0] max_lane3;
    logic        window_empty;
    modport source (output valid, max_lane0, max_lane1, max_lane2, max_lane3, window_empty,
                    input ready);
    modport sink (input valid, max_lane0, max_lane1, max_lane2, max_lane3, window_empty,
                  output ready);
endinterface

// ----- hw/rtl/mpp_cfg.sv -----
module mpp_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output mpp_pkg::t_cfg       o_cfg
);
    mpp_pkg::t_cfg r_cfg;
    logic [3:0]    w_idx;
    logic          w_wr;

    assign w_idx  = {1'b0, paddr[4:2]};
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kernel_height <= 7'd1;
            r_cfg.kernel_width  <= 7'd1;
            r_cfg.stride_height <= 7'd1;
            r_cfg.stride_width  <= 7'd1;
            r_cfg.pad_top       <= 6'd0;
            r_cfg.pad_left      <= 6'd0;
            r_cfg.image_height  <= 7'd64;
            r_cfg.image_width   <= 7'd64;
        end else if (w_wr) begin
            unique case (w_idx)
                mpp_pkg::RegKh: r_cfg.kernel_height <= pwdata[6:0];
                mpp_pkg::RegKw: r_cfg.kernel_width  <= pwdata[6:0];
                mpp_pkg::RegSh: r_cfg.stride_height <= pwdata[6:0];
                mpp_pkg::RegSw: r_cfg.stride_width  <= pwdata[6:0];
                mpp_pkg::RegPt: r_cfg.pad_top       <= pwdata[5:0];
                mpp_pkg::RegPl: r_cfg.pad_left      <= pwdata[5:0];
                mpp_pkg::RegIh: r_cfg.image_height  <= pwdata[6:0];
                default:        r_cfg.image_width   <= pwdata[6:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            mpp_pkg::RegKh: prdata = {25'd0, r_cfg.kernel_height};
            mpp_pkg::RegKw: prdata = {25'd0, r_cfg.kernel_width};
            mpp_pkg::RegSh: prdata = {25'd0, r_cfg.stride_height};
            mpp_pkg::RegSw: prdata = {25'd0, r_cfg.stride_width};
            mpp_pkg::RegPt: prdata = {26'd0, r_cfg.pad_top};
            mpp_pkg::RegPl: prdata = {26'd0, r_cfg.pad_left};
            mpp_pkg::RegIh: prdata = {25'd0, r_cfg.image_height};
            default:        prdata = {25'd0, r_cfg.image_width};
        endcase
    end
endmodule

// ----- hw/rtl/mpp_store.sv -----
module mpp_store (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [mpp_pkg::AddrW-1:0]     i_waddr,
    input  logic [mpp_pkg::LaneBits-1:0]  i_wdata,
    input  logic [mpp_pkg::AddrW-1:0]     i_raddr,
    output logic [mpp_pkg::LaneBits-1:0]  o_rdata
);
    localparam int Depth = 1 << mpp_pkg::AddrW;
    logic [mpp_pkg::LaneBits-1:0] r_mem [Depth];
    logic [mpp_pkg::LaneBits-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/max_pool_2d_padded_unit.sv -----
// max_pool_2d_padded_unit
// Input channel (mpp_in_if): a load word writes four fp32 channels of one
// pixel slice into the pixel store; loads outside the image are dropped. A
// query word names output row, col and slice; one result word is
// produced with the four lane maxima and window_empty.
// The user must write configuration through the APB port only while the
// block is idle; the block itself does not enforce this.
// Sequence: a load is written at its accept edge and the block is ready again
// in the next cycle. A query passes a setup state, then for each clipped
// window pixel a store read and then the per-lane compares, one final
// bounds check and an output state that loads the result. The single
// registered store read port sets the pace. An empty window yields +0.0
// lanes and window_empty.
// The block takes one word at a time; i_in.ready is high only when idle.
// The result is held in its register while the receiver stalls.
// Reset clears the sequencer state and the result valid flag; store contents
// are undefined until written.
module max_pool_2d_padded_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mpp_in_if.sink         i_in,
    mpp_out_if.source      o_out,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [4:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    mpp_pkg::t_cfg   w_cfg;
    mpp_pkg::t_state r_state, n_state;

    logic [1:0]  r_slice;
    logic [7:0]  r_hs, r_ws, r_he, r_we;     // clipped bounds
    logic [7:0]  r_r, r_c;
    logic [31:0] r_run [mpp_pkg::Lanes];
    logic        r_empty;
    logic [13:0] r_ph, r_pw;                 // products
    logic        r_vld;

    logic        w_acc, w_load_ok;
    logic [6:0]  w_h, w_w;
    logic        w_we;
    logic [mpp_pkg::AddrW-1:0] w_waddr, w_raddr;
    logic [mpp_pkg::LaneBits-1:0] w_wdata, w_rdata;
    logic signed [15:0] w_hs, w_ws, w_he, w_we2;

    mpp_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .o_cfg(w_cfg)
    );

    assign w_h = (w_cfg.image_height > 7'(mpp_pkg::MaxHeight)) ?
                 7'(mpp_pkg::MaxHeight) : w_cfg.image_height;
    assign w_w = (w_cfg.image_width > 7'(mpp_pkg::MaxWidth)) ?
                 7'(mpp_pkg::MaxWidth) : w_cfg.image_width;

    assign i_in.ready = (r_state == mpp_pkg::S_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_load_ok  = (i_in.row < w_h) && (i_in.col < w_w);
    assign w_we       = w_acc && (i_in.action == mpp_pkg::ActLoad) && w_load_ok;
    assign w_waddr    = {i_in.row[mpp_pkg::RowW-1:0], i_in.col[mpp_pkg::ColW-1:0],
                         i_in.slice};
    assign w_wdata    = {i_in.in_lane3, i_in.in_lane2, i_in.in_lane1, i_in.in_lane0};
    assign w_raddr    = {r_r[mpp_pkg::RowW-1:0], r_c[mpp_pkg::ColW-1:0], r_slice};

    mpp_store u_store (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    assign w_hs  = $signed({2'b0, r_ph}) - $signed({10'd0, w_cfg.pad_top});
    assign w_ws  = $signed({2'b0, r_pw}) - $signed({10'd0, w_cfg.pad_left});
    assign w_he  = w_hs + $signed({9'd0, w_cfg.kernel_height});
    assign w_we2 = w_ws + $signed({9'd0, w_cfg.kernel_width});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpp_pkg::S_IDLE;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_out.valid && o_out.ready) begin
                r_vld <= 1'b0;
            end
            if (r_state == mpp_pkg::S_OUT && !r_vld) begin
                r_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            mpp_pkg::S_IDLE: begin
                r_slice <= i_in.slice;
                r_ph    <= i_in.row * w_cfg.stride_height;
                r_pw    <= i_in.col * w_cfg.stride_width;
            end
            mpp_pkg::S_SETUP: begin
                r_hs <= w_hs[15] ? 8'd0 :
                        ((w_hs > $signed(16'(mpp_pkg::MaxHeight))) ?
                         8'(mpp_pkg::MaxHeight) : w_hs[7:0]);
                r_ws <= w_ws[15] ? 8'd0 :
                        ((w_ws > $signed(16'(mpp_pkg::MaxWidth))) ?
                         8'(mpp_pkg::MaxWidth) : w_ws[7:0]);
                r_he <= w_he[15] ? 8'd0 :
                        ((w_he > $signed({9'd0, w_h})) ? {1'b0, w_h} : w_he[7:0]);
                r_we <= w_we2[15] ? 8'd0 :
                        ((w_we2 > $signed({9'd0, w_w})) ? {1'b0, w_w} : w_we2[7:0]);
                r_r  <= w_hs[15] ? 8'd0 : w_hs[7:0];
                r_c  <= w_ws[15] ? 8'd0 : w_ws[7:0];
                for (int l = 0; l < mpp_pkg::Lanes; l++) begin
                    r_run[l] <= mpp_pkg::NegFltMax;
                end
            end
            mpp_pkg::S_READ: begin
                r_empty <= (r_hs >= r_he) || (r_ws >= r_we);
            end
            mpp_pkg::S_CMP: begin
                for (int l = 0; l < mpp_pkg::Lanes; l++) begin
                    if (!mpp_pkg::fp_gt(r_run[l], w_rdata[32*l +: 32])) begin
                        r_run[l] <= w_rdata[32*l +: 32];
                    end
                end
                if (r_c + 8'd1 >= r_we) begin
                    r_c <= r_ws;
                    r_r <= r_r + 8'd1;
                end else begin
                    r_c <= r_c + 8'd1;
                end
            end
            default: begin
                if (r_empty && !r_vld) begin
                    for (int l = 0; l < mpp_pkg::Lanes; l++) begin
                        r_run[l] <= 32'd0;
                    end
                end
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mpp_pkg::S_IDLE: begin
                if (w_acc && i_in.action == mpp_pkg::ActQuery) begin
                    n_state = mpp_pkg::S_SETUP;
                end
            end
            mpp_pkg::S_SETUP: n_state = mpp_pkg::S_READ;
            mpp_pkg::S_READ: begin
                if ((r_hs >= r_he) || (r_ws >= r_we) || (r_r >= r_he)) begin
                    n_state = mpp_pkg::S_OUT;
                end else begin
                    n_state = mpp_pkg::S_CMP;
                end
            end
            mpp_pkg::S_CMP: n_state = mpp_pkg::S_READ;
            default: begin
                if (r_vld && o_out.ready) begin
                    n_state = mpp_pkg::S_IDLE;
                end
            end
        endcase
    end

    assign o_out.valid        = r_vld;
    assign o_out.max_lane0    = r_run[0];
    assign o_out.max_lane1    = r_run[1];
    assign o_out.max_lane2    = r_run[2];
    assign o_out.max_lane3    = r_run[3];
    assign o_out.window_empty = r_empty;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> !i_in.ready) else $error("ready while result pending");
    a_vld_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> r_state == mpp_pkg::S_OUT) else $error("result outside out state");
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> r_state == mpp_pkg::S_IDLE) else $error("store write while busy");
endmodule

// ----- dv/mpp_pool_checker.sv -----
`timescale 1ns / 100ps

module mpp_pool_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mpp_in_if           in_w,
    mpp_out_if          out_w,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_cnt,
    output int          o_pending
);
    typedef struct packed {
        logic [31:0] lane0;
        logic [31:0] lane1;
        logic [31:0] lane2;
        logic [31:0] lane3;
        logic        empty;
    } t_pool_res;

    logic [31:0]   px_mem [0:mpp_pkg::MaxHeight*mpp_pkg::MaxWidth*mpp_pkg::ChannelBlock-1];
    mpp_pkg::t_cfg cfg;
    t_pool_res     exp_max_q [$];
    int            fail_cnt = 0;

    assign o_pending  = exp_max_q.size();
    assign o_fail_cnt = fail_cnt;

    function automatic bit is_nan(logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 0);
    endfunction

    // order key: monotonic unsigned mapping of fp32; both zeros map alike
    function automatic logic [31:0] order_key(logic [31:0] v);
        if (v[30:0] == 0) begin
            return 32'h8000_0000;
        end
        return v[31] ? ~v : (v | 32'h8000_0000);
    endfunction

    function automatic bit fgt(logic [31:0] a, logic [31:0] b);
        if (is_nan(a) || is_nan(b)) begin
            return 1'b0;
        end
        return order_key(a) > order_key(b);
    endfunction

    function automatic t_pool_res pool_window(int qr, int qc, int qs);
        t_pool_res   res;
        logic [31:0] run [4];
        logic [31:0] smp;
        int h, w, hs, he, ws, we;
        h  = (cfg.image_height > mpp_pkg::MaxHeight) ? mpp_pkg::MaxHeight : cfg.image_height;
        w  = (cfg.image_width > mpp_pkg::MaxWidth) ? mpp_pkg::MaxWidth : cfg.image_width;
        hs = qr * cfg.stride_height - cfg.pad_top;
        ws = qc * cfg.stride_width - cfg.pad_left;
        he = hs + cfg.kernel_height;
        we = ws + cfg.kernel_width;
        if (he > h) he = h;
        if (we > w) we = w;
        if (hs < 0) hs = 0;
        if (ws < 0) ws = 0;
        res = '0;
        if (hs >= he || ws >= we) begin
            res.empty = 1'b1;
            return res;
        end
        for (int l = 0; l < 4; l++) run[l] = mpp_pkg::NegFltMax;
        for (int r = hs; r < he; r++) begin
            for (int c = ws; c < we; c++) begin
                for (int l = 0; l < 4; l++) begin
                    smp = px_mem[(r*mpp_pkg::MaxWidth + c)*mpp_pkg::ChannelBlock +
                                 ((qs*mpp_pkg::Lanes + l) % mpp_pkg::ChannelBlock)];
                    if (!fgt(run[l], smp)) run[l] = smp;
                end
            end
        end
        res.lane0 = run[0];
        res.lane1 = run[1];
        res.lane2 = run[2];
        res.lane3 = run[3];
        return res;
    endfunction

    always @(posedge i_clk) begin
        int base;
        int h, w;
        if (!i_rst_n) begin
            cfg <= '{kernel_height: 7'd1, kernel_width: 7'd1, stride_height: 7'd1,
                     stride_width: 7'd1, pad_top: 6'd0, pad_left: 6'd0,
                     image_height: 7'd64, image_width: 7'd64};
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    mpp_pkg::RegKh[2:0]: cfg.kernel_height <= i_pwdata[6:0];
                    mpp_pkg::RegKw[2:0]: cfg.kernel_width  <= i_pwdata[6:0];
                    mpp_pkg::RegSh[2:0]: cfg.stride_height <= i_pwdata[6:0];
                    mpp_pkg::RegSw[2:0]: cfg.stride_width  <= i_pwdata[6:0];
                    mpp_pkg::RegPt[2:0]: cfg.pad_top       <= i_pwdata[5:0];
                    mpp_pkg::RegPl[2:0]: cfg.pad_left      <= i_pwdata[5:0];
                    mpp_pkg::RegIh[2:0]: cfg.image_height  <= i_pwdata[6:0];
                    default:             cfg.image_width   <= i_pwdata[6:0];
                endcase
            end
            if (in_w.valid && in_w.ready) begin
                if (in_w.action == mpp_pkg::ActLoad) begin
                    h = (cfg.image_height > mpp_pkg::MaxHeight) ?
                        mpp_pkg::MaxHeight : cfg.image_height;
                    w = (cfg.image_width > mpp_pkg::MaxWidth) ?
                        mpp_pkg::MaxWidth : cfg.image_width;
                    if (in_w.row < h && in_w.col < w) begin
                        base = (in_w.row*mpp_pkg::MaxWidth + in_w.col)*mpp_pkg::ChannelBlock;
                        px_mem[base + ((in_w.slice*mpp_pkg::Lanes + 0) % mpp_pkg::ChannelBlock)]
                            = in_w.in_lane0;
                        px_mem[base + ((in_w.slice*mpp_pkg::Lanes + 1) % mpp_pkg::ChannelBlock)]
                            = in_w.in_lane1;
                        px_mem[base + ((in_w.slice*mpp_pkg::Lanes + 2) % mpp_pkg::ChannelBlock)]
                            = in_w.in_lane2;
                        px_mem[base + ((in_w.slice*mpp_pkg::Lanes + 3) % mpp_pkg::ChannelBlock)]
                            = in_w.in_lane3;
                    end
                end else begin
                    exp_max_q.push_back(pool_window(in_w.row, in_w.col, in_w.slice));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_pool_res got;
        t_pool_res want;
        if (i_rst_n && out_w.valid && out_w.ready) begin
            got = '{out_w.max_lane0, out_w.max_lane1, out_w.max_lane2, out_w.max_lane3,
                    out_w.window_empty};
            if (exp_max_q.size() == 0) begin
                $display("%0t: unexpected result word %h", $realtime, got);
                fail_cnt <= fail_cnt + 1;
            end else begin
                want = exp_max_q.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch exp %h %h %h %h e%b got %h %h %h %h e%b", $realtime,
                             want.lane0, want.lane1, want.lane2, want.lane3, want.empty,
                             got.lane0, got.lane1, got.lane2, got.lane3, got.empty);
                    fail_cnt <= fail_cnt + 1;
                end
            end
        end
    end

endmodule

// ----- dv/max_pool_2d_padded_unit_tb.sv -----
`timescale 1ns / 100ps

module max_pool_2d_padded_unit_tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_cnt;
    int          pending;

    mpp_in_if  in_w();
    mpp_out_if out_w();

    max_pool_2d_padded_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_w),
        .o_out   (out_w),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    mpp_pool_checker u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_w       (in_w),
        .out_w      (out_w),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_pready   (pready),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    // 0 none, 1 sender gaps, 2 receiver stalls, 3 both light
    int idle_mode;
    int hold_req;
    bit written [0:mpp_pkg::MaxHeight*mpp_pkg::MaxWidth*4-1];
    int kh, kw, sh, sw, pt, pl, ih, iw;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("max_pool_2d_padded_unit_tb: errors");
        $finish;
    end

    initial begin
        int hold_seen;
        hold_seen = 0;
        out_w.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_req != hold_seen) begin
                out_w.ready = 1'b0;
                repeat (400) @(negedge i_clk);
                hold_seen = hold_req;
            end else begin
                case (idle_mode)
                    2:       out_w.ready = ($urandom_range(99) >= 58);
                    3:       out_w.ready = ($urandom_range(99) >= 11);
                    default: out_w.ready = 1'b1;
                endcase
                @(negedge i_clk);
            end
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(9))
            0: return 32'h7FC0_0000 | $urandom_range(32'h3F_FFFF);
            1: return 32'hFFFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'h8000_0000;
            4: return ($urandom_range(1) ? 32'h7F80_0000 : 32'hFF80_0000);
            5: return ($urandom_range(1) ? 32'h7F7F_FFFF : 32'hFF7F_FFFF);
            default: return $urandom;
        endcase
    endfunction

    function automatic int img_h();
        return (ih > mpp_pkg::MaxHeight) ? mpp_pkg::MaxHeight : ih;
    endfunction

    function automatic int img_w();
        return (iw > mpp_pkg::MaxWidth) ? mpp_pkg::MaxWidth : iw;
    endfunction

    function automatic bit query_ok(int qr, int qc, int qs);
        int hs, he, ws, we;
        hs = qr * sh - pt;
        ws = qc * sw - pl;
        he = hs + kh;
        we = ws + kw;
        if (he > img_h()) he = img_h();
        if (we > img_w()) we = img_w();
        if (hs < 0) hs = 0;
        if (ws < 0) ws = 0;
        for (int r = hs; r < he; r++) begin
            for (int c = ws; c < we; c++) begin
                if (!written[(r*mpp_pkg::MaxWidth + c)*4 + qs]) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic apb_write(logic [3:0] idx, logic [31:0] val);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx[2:0], 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_word(logic act, int r, int c, int s, logic [31:0] l0,
                             logic [31:0] l1, logic [31:0] l2, logic [31:0] l3);
        int gap;
        gap = 0;
        if (idle_mode == 1 && $urandom_range(99) < 58) gap = $urandom_range(1, 4);
        if (idle_mode == 3 && $urandom_range(99) < 11) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            in_w.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_w.valid    = 1'b1;
        in_w.action   = act;
        in_w.row      = r[6:0];
        in_w.col      = c[6:0];
        in_w.slice    = s[1:0];
        in_w.in_lane0 = l0;
        in_w.in_lane1 = l1;
        in_w.in_lane2 = l2;
        in_w.in_lane3 = l3;
        do @(posedge i_clk); while (!in_w.ready);
        if (act == mpp_pkg::ActLoad && r < img_h() && c < img_w())
            written[(r*mpp_pkg::MaxWidth + c)*4 + s] = 1'b1;
        @(negedge i_clk);
    endtask

    task automatic send_load(int r, int c, int s);
        send_word(mpp_pkg::ActLoad, r, c, s, rand_word(), rand_word(), rand_word(),
                  rand_word());
    endtask

    task automatic send_query(int r, int c, int s);
        send_word(mpp_pkg::ActQuery, r, c, s, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic drain();
        in_w.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic set_cfg(int a, int b, int c, int d, int e, int f, int g, int h);
        kh = a; kw = b; sh = c; sw = d; pt = e; pl = f; ih = g; iw = h;
        apb_write(mpp_pkg::RegKh, kh);
        apb_write(mpp_pkg::RegKw, kw);
        apb_write(mpp_pkg::RegSh, sh);
        apb_write(mpp_pkg::RegSw, sw);
        apb_write(mpp_pkg::RegPt, pt);
        apb_write(mpp_pkg::RegPl, pl);
        apb_write(mpp_pkg::RegIh, ih);
        apb_write(mpp_pkg::RegIw, iw);
    endtask

    task automatic run_phase(int n);
        int fh, fw, rmax, cmax, qr, qc, qs, tries;
        bit ok;
        fh = (img_h() > 6) ? 6 : img_h();
        fw = (img_w() > 6) ? 6 : img_w();
        for (int r = 0; r < fh; r++)
            for (int c = 0; c < fw; c++)
                for (int s = 0; s < 4; s++) send_load(r, c, s);
        rmax = (sh == 0) ? 3 : (fh + pt) / sh + 1;
        cmax = (sw == 0) ? 3 : (fw + pl) / sw + 1;
        if (rmax > 127) rmax = 127;
        if (cmax > 127) cmax = 127;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 25) begin
                send_load($urandom_range(127) % ($urandom_range(1) ? 128 : fh + 2),
                          $urandom_range(127) % ($urandom_range(1) ? 128 : fw + 2),
                          $urandom_range(3));
            end else begin
                ok = 1'b0;
                tries = 0;
                while (!ok && tries < 30) begin
                    qr = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(rmax);
                    qc = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(cmax);
                    qs = $urandom_range(3);
                    ok = query_ok(qr, qc, qs);
                    tries++;
                end
                if (ok) send_query(qr, qc, qs);
                else send_load($urandom_range(fh - 1), $urandom_range(fw - 1), $urandom_range(3));
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_w.valid  = 1'b0;
        in_w.action = mpp_pkg::ActLoad;
        in_w.row    = '0;
        in_w.col    = '0;
        in_w.slice  = '0;
        in_w.in_lane0 = '0;
        in_w.in_lane1 = '0;
        in_w.in_lane2 = '0;
        in_w.in_lane3 = '0;
        idle_mode   = 0;
        hold_req    = 0;
        kh = 1; kw = 1; sh = 1; sw = 1; pt = 0; pl = 0; ih = 64; iw = 64;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: reset defaults, then padded 2x2 image with special values
        send_word(mpp_pkg::ActLoad, 0, 0, 0, 32'h7FC0_0001, 32'h8000_0000, 32'hFF80_0000,
                  32'h0);
        send_query(0, 0, 0);
        drain();
        set_cfg(3, 3, 2, 2, 1, 1, 2, 2);
        send_word(mpp_pkg::ActLoad, 0, 0, 0, 32'h0000_0000, 32'h8000_0000, 32'hFF80_0000,
                  32'h7F80_0000);
        send_word(mpp_pkg::ActLoad, 0, 1, 0, 32'h8000_0000, 32'h0000_0000, 32'hFF7F_FFFF,
                  32'hFFFF_FFFF);
        send_word(mpp_pkg::ActLoad, 1, 0, 0, 32'hFFC0_0000, 32'h3F80_0000, 32'hFF80_0000,
                  32'h7F7F_FFFF);
        send_word(mpp_pkg::ActLoad, 1, 1, 0, 32'h7F80_0000, 32'hBF80_0000, 32'hFF80_0000,
                  32'h0000_0001);
        send_word(mpp_pkg::ActLoad, 127, 127, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
        send_word(mpp_pkg::ActLoad, 2, 0, 1, $urandom, $urandom, $urandom, $urandom);
        send_word(mpp_pkg::ActLoad, 0, 2, 2, $urandom, $urandom, $urandom, $urandom);
        send_query(0, 0, 0);
        send_query(1, 1, 0);
        send_query(0, 1, 0);
        send_query(127, 127, 3);
        send_query(5, 0, 2);
        drain();

        set_cfg(1, 1, 1, 1, 0, 0, 64, 64);
        run_phase(80);
        drain();
        idle_mode = 1;
        set_cfg(3, 3, 2, 2, 1, 1, 8, 8);
        hold_req++;
        run_phase(100);
        drain();
        idle_mode = 2;
        set_cfg(64, 64, 64, 64, 63, 63, 6, 6);
        run_phase(30);
        drain();
        idle_mode = 3;
        set_cfg(2, 5, 1, 3, 0, 2, 5, 7);
        run_phase(35);
        drain();
        run_phase(40);
        drain();
        idle_mode = 1;
        set_cfg(0, 3, 0, 1, 0, 0, 4, 4);
        run_phase(30);
        drain();
        idle_mode = 2;
        set_cfg(4, 4, 3, 3, 2, 2, 127, 127);
        run_phase(60);
        drain();
        idle_mode = 3;
        set_cfg(7, 2, 0, 2, 6, 0, 3, 9);
        run_phase(75);
        drain();
        idle_mode = 0;
        set_cfg(127, 1, 127, 127, 0, 0, 64, 1);
        run_phase(20);
        drain();
        repeat (20) @(negedge i_clk);
        if (fail_cnt == 0) begin
            $display("max_pool_2d_padded_unit_tb: clean");
        end else begin
            $display("max_pool_2d_padded_unit_tb: errors");
        end
        $finish;
    end

endmodule
